// File: design/bmc_tx_pkg.sv
// ----------------------------------------------------------------------------
// bmc_tx_pkg
// Shared types, constants and the BMC half-bit table of the frame encoder.
// ----------------------------------------------------------------------------
package bmc_tx_pkg;

  // Preamble length in line bytes at the start of every frame (1 to 64).
  localparam int unsigned PREAMBLE_BYTES = 16;
  localparam int unsigned PreCntW        = $clog2(PREAMBLE_BYTES + 1);

  // Depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPtrW       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCntW       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] PREAMBLE_CODE = 8'hD2;

  // End-of-packet bytes, chosen by line polarity.
  localparam logic [7:0] EOP_FIRST_POS  = 8'hB5;
  localparam logic [7:0] EOP_SECOND_POS = 8'h3F;
  localparam logic [7:0] EOP_FIRST_NEG  = 8'h4A;
  localparam logic [7:0] EOP_SECOND_NEG = 8'hCF;

  // One classified frame byte.
  typedef struct packed {
    logic [7:0] data;
    logic       last;   // final byte of the frame
    logic       start;  // first byte of the frame, preamble goes first
  } item_t;

  function automatic logic [7:0] half_bit(input logic [3:0] nib);
    logic [7:0] code;
    unique case (nib)
      4'h0: code = 8'hCC;
      4'h1: code = 8'hCD;
      4'h2: code = 8'hCB;
      4'h3: code = 8'hCA;
      4'h4: code = 8'hD3;
      4'h5: code = 8'hD2;
      4'h6: code = 8'hD4;
      4'h7: code = 8'hD5;
      4'h8: code = 8'hB3;
      4'h9: code = 8'hB2;
      4'hA: code = 8'hB4;
      4'hB: code = 8'hB5;
      4'hC: code = 8'hAC;
      4'hD: code = 8'hAD;
      4'hE: code = 8'hAB;
      4'hF: code = 8'hAA;
      default: code = 8'hCC;
    endcase
    return code;
  endfunction

endpackage

// File: design/bmc_tx_front.sv
// ----------------------------------------------------------------------------
// bmc_tx_front
// Accepts frame bytes and tags the first byte of each frame.
// ----------------------------------------------------------------------------
module bmc_tx_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       data_byte_i,
  input  logic             frame_last_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output bmc_tx_pkg::item_t q_item_o
);
  import bmc_tx_pkg::*;

  logic in_frame_q, in_frame_d;

  assign full     = q_full_i;
  assign q_push_o = push && !q_full_i;

  assign q_item_o.data  = data_byte_i;
  assign q_item_o.last  = frame_last_i;
  assign q_item_o.start = !in_frame_q;

  always_comb begin
    in_frame_d = in_frame_q;
    if (q_push_o) begin
      in_frame_d = !frame_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
    end
  end

endmodule

// File: design/bmc_tx_queue.sv
// ----------------------------------------------------------------------------
// bmc_tx_queue
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module bmc_tx_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bmc_tx_pkg::item_t item_i,
  output logic              full_o,
  input  logic              pop_i,
  output bmc_tx_pkg::item_t head_o,
  output logic              empty_o
);
  import bmc_tx_pkg::*;

  item_t            slot_q [QUEUE_DEPTH];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue pop while empty");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

// File: design/bmc_tx_back.sv
// ----------------------------------------------------------------------------
// bmc_tx_back
// Sequences preamble, BMC payload and EOP bytes into the result register.
// ----------------------------------------------------------------------------
module bmc_tx_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  bmc_tx_pkg::item_t q_head_i,
  input  logic              q_empty_i,
  output logic              q_pop_o,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        line_byte_o,
  output logic              run_last_o,
  output logic              frame_done_o
);
  import bmc_tx_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PRE,
    PH_HI,
    PH_LO,
    PH_EOP1,
    PH_EOP2
  } phase_e;

  phase_e             phase_q, phase_d;
  item_t              cur_q, cur_d;
  logic [PreCntW-1:0] pre_cnt_q, pre_cnt_d;
  logic               pol_q, pol_d;
  logic               line_invert_q, line_invert_d;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         out_byte_q, out_byte_d;
  logic               out_last_q, out_last_d;
  logic               out_done_q, out_done_d;

  logic       adv;
  logic       finish;
  logic       load;
  logic       emit_vld;
  logic [7:0] emit_byte;
  logic       emit_last;
  logic       emit_done;
  logic [3:0] nib;
  logic [7:0] tbl;
  logic [7:0] tbl_pol;

  // Result register frees up when empty or being taken.
  assign adv = !out_valid_q || pop;

  assign nib     = (phase_q == PH_HI) ? cur_q.data[7:4] : cur_q.data[3:0];
  assign tbl     = half_bit(nib);
  assign tbl_pol = pol_q ? tbl : ~tbl;

  always_comb begin
    phase_d   = phase_q;
    pre_cnt_d = pre_cnt_q;
    pol_d     = pol_q;
    emit_vld  = 1'b0;
    emit_byte = '0;
    emit_last = 1'b0;
    emit_done = 1'b0;
    finish    = 1'b0;

    unique case (phase_q)
      PH_IDLE: begin
      end
      PH_PRE: begin
        emit_vld  = 1'b1;
        emit_byte = PREAMBLE_CODE;
        if (adv) begin
          if (pre_cnt_q == PreCntW'(PREAMBLE_BYTES - 1)) begin
            phase_d = PH_HI;
          end else begin
            pre_cnt_d = pre_cnt_q + 1'b1;
          end
        end
      end
      PH_HI: begin
        emit_vld  = 1'b1;
        emit_byte = tbl_pol;
        if (adv) begin
          pol_d   = pol_q ^ tbl[0];
          phase_d = PH_LO;
        end
      end
      PH_LO: begin
        emit_vld  = 1'b1;
        emit_byte = tbl_pol;
        emit_last = !cur_q.last;
        if (adv) begin
          pol_d = pol_q ^ tbl[0];
          if (cur_q.last) begin
            phase_d = PH_EOP1;
          end else begin
            finish = 1'b1;
          end
        end
      end
      PH_EOP1: begin
        emit_vld  = 1'b1;
        emit_byte = pol_q ? EOP_FIRST_POS : EOP_FIRST_NEG;
        if (adv) begin
          phase_d = PH_EOP2;
        end
      end
      PH_EOP2: begin
        emit_vld  = 1'b1;
        emit_byte = pol_q ? EOP_SECOND_POS : EOP_SECOND_NEG;
        emit_last = 1'b1;
        emit_done = 1'b1;
        if (adv) begin
          finish = 1'b1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    // Pick up the next item while idle or in the cycle that emits the current item's last byte.
    load = !q_empty_i && ((phase_q == PH_IDLE) || finish);

    if (finish) begin
      phase_d = PH_IDLE;
    end
    cur_d = cur_q;
    if (load) begin
      cur_d     = q_head_i;
      pre_cnt_d = '0;
      phase_d   = q_head_i.start ? PH_PRE : PH_HI;
      if (q_head_i.start) begin
        pol_d = 1'b1;
      end
    end
  end

  assign q_pop_o = load;

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_done_d  = out_done_q;
    if (adv) begin
      out_valid_d = emit_vld;
      out_byte_d  = line_invert_q ? emit_byte : ~emit_byte;
      out_last_d  = emit_last;
      out_done_d  = emit_done;
    end
    line_invert_d = cfg_we_i ? cfg_wdata_i : line_invert_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      cur_q         <= '0;
      pre_cnt_q     <= '0;
      pol_q         <= 1'b1;
      line_invert_q <= 1'b1;
      out_valid_q   <= 1'b0;
      out_byte_q    <= '0;
      out_last_q    <= 1'b0;
      out_done_q    <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      cur_q         <= cur_d;
      pre_cnt_q     <= pre_cnt_d;
      pol_q         <= pol_d;
      line_invert_q <= line_invert_d;
      out_valid_q   <= out_valid_d;
      out_byte_q    <= out_byte_d;
      out_last_q    <= out_last_d;
      out_done_q    <= out_done_d;
    end
  end

  assign empty        = !out_valid_q;
  assign line_byte_o  = out_byte_q;
  assign run_last_o   = out_last_q;
  assign frame_done_o = out_done_q;

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_done_q) |-> out_last_q)
    else $error("frame end without item end");

  a_pre_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PRE) |-> (pre_cnt_q < PreCntW'(PREAMBLE_BYTES)))
    else $error("preamble count out of range");

  a_start_pol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && q_head_i.start) |=> pol_q)
    else $error("polarity not set at frame start");

  // A busy sequencer holds while the result waits; an idle one may load the next item.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop && (phase_q != PH_IDLE))
      |=> ($stable(out_byte_q) && out_valid_q && $stable(phase_q)))
    else $error("sequencer moved while result stalled");

endmodule

// File: design/bmc_frame_transmit_encoder.sv
// Path: an accepted item passes the queue slot and the back's item register, then its
// first line byte enters the result register. Throughput: one line byte per cycle while
// pop takes the result, set by the back sequencer; a mid-frame item gives two line bytes
// (high and low nibble), a frame's first item PREAMBLE_BYTES more, its last two for EOP.
// Reset: idle between frames, polarity 1, line_invert 1, queue and result register empty.
// ----------------------------------------------------------------------------
// bmc_frame_transmit_encoder
// BMC line encoder for frame bytes with preamble and EOP generation.
// ----------------------------------------------------------------------------
module bmc_frame_transmit_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       frame_last_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] line_byte_o,
  output logic       run_last_o,
  output logic       frame_done_o
);
  import bmc_tx_pkg::*;

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  item_t q_item;
  item_t q_head;

  bmc_tx_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .data_byte_i  (data_byte_i),
    .frame_last_i (frame_last_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_item_o     (q_item)
  );

  bmc_tx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty)
  );

  bmc_tx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_head_i     (q_head),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .empty        (empty),
    .pop          (pop),
    .line_byte_o  (line_byte_o),
    .run_last_o   (run_last_o),
    .frame_done_o (frame_done_o)
  );

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BMC frame encoder testbench
// Pushes frame bytes (one-byte frames, long frames, all nibble codes) into the
// encoder and checks every line byte, the run_last and frame_done flags
// against an in-bench model of preamble, half-bit coding, polarity and EOP.
// Covers both line_invert settings under sender and receiver idling.
// ----------------------------------------------------------------------------
module testbench;
  import bmc_tx_pkg::PREAMBLE_BYTES;

  localparam logic [7:0] HALF_BIT [16] = '{
    8'hCC, 8'hCD, 8'hCB, 8'hCA, 8'hD3, 8'hD2, 8'hD4, 8'hD5,
    8'hB3, 8'hB2, 8'hB4, 8'hB5, 8'hAC, 8'hAD, 8'hAB, 8'hAA
  };
  localparam logic [7:0] SYNC_CODE  = 8'hD2;
  localparam logic [7:0] EOP_A_POS  = 8'hB5;
  localparam logic [7:0] EOP_B_POS  = 8'h3F;
  localparam logic [7:0] EOP_A_NEG  = 8'h4A;
  localparam logic [7:0] EOP_B_NEG  = 8'hCF;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_last;
    logic       frame_done;
  } line_rec_t;

  class bmc_scoreboard;
    line_rec_t line_q[$];
    bit        invert_cfg = 1'b1;
    bit        polarity   = 1'b1;
    bit        framing    = 1'b0;
    int        errors     = 0;
    int        n_items    = 0;
    int        n_frames   = 0;
    int        n_bytes    = 0;

    function int pending();
      return line_q.size();
    endfunction

    function void add_line(logic [7:0] b, logic done);
      line_rec_t rec;
      rec.line_byte  = invert_cfg ? b : ~b;
      rec.run_last   = 1'b0;
      rec.frame_done = done;
      line_q.push_back(rec);
    endfunction

    function void add_nibble(logic [3:0] nib);
      logic [7:0] code;
      code = HALF_BIT[nib];
      add_line(polarity ? code : ~code, 1'b0);
      polarity = polarity ^ code[0];
    endfunction

    // Predict the line bytes caused by one accepted frame byte.
    function void note_item(logic [7:0] data, logic last);
      n_items++;
      if (!framing) begin
        repeat (PREAMBLE_BYTES) add_line(SYNC_CODE, 1'b0);
        polarity = 1'b1;
        framing  = 1'b1;
      end
      add_nibble(data[7:4]);
      add_nibble(data[3:0]);
      if (last) begin
        if (polarity) begin
          add_line(EOP_A_POS, 1'b0);
          add_line(EOP_B_POS, 1'b1);
        end else begin
          add_line(EOP_A_NEG, 1'b0);
          add_line(EOP_B_NEG, 1'b1);
        end
        framing = 1'b0;
        n_frames++;
      end
      line_q[line_q.size() - 1].run_last = 1'b1;
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_line(logic [7:0] lb, logic rl, logic fd);
      line_rec_t want;
      n_bytes++;
      if (line_q.size() == 0) begin
        report($sformatf("unexpected line byte %02h", lb));
      end else begin
        want = line_q.pop_front();
        if (lb !== want.line_byte)
          report($sformatf("line_byte %02h, want %02h", lb, want.line_byte));
        if (rl !== want.run_last)
          report($sformatf("run_last %b, want %b", rl, want.run_last));
        if (fd !== want.frame_done)
          report($sformatf("frame_done %b, want %b", fd, want.frame_done));
      end
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] data_byte_i = 8'h00;
  logic       frame_last_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] line_byte_o;
  logic       run_last_o;
  logic       frame_done_o;

  int send_idle = 0;
  int recv_idle = 0;

  bmc_scoreboard sb = new();

  bmc_frame_transmit_encoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .data_byte_i  (data_byte_i),
    .frame_last_i (frame_last_i),
    .empty        (empty),
    .pop          (pop),
    .line_byte_o  (line_byte_o),
    .run_last_o   (run_last_o),
    .frame_done_o (frame_done_o)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // Take line bytes and stall at random.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) sb.check_line(line_byte_o, run_last_o, frame_done_o);
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_item(input logic [7:0] data, input logic last);
    if ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    push         <= 1'b1;
    data_byte_i  <= data;
    frame_last_i <= last;
    do @(posedge clk_i); while (full);
    sb.note_item(data, last);
  endtask

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) send_item(8'($urandom_range(255)), i == len - 1);
  endtask

  // Hold the sender until every predicted line byte has come out.
  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_invert(input logic value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.invert_cfg = value;
  endtask

  task automatic run_random(input int n, input int s_idle, input int r_idle,
                            input logic invert, input bit pause_mid);
    int start;
    int r;
    bit paused;
    drain();
    write_invert(invert);
    send_idle = s_idle;
    recv_idle = r_idle;
    start  = sb.n_items;
    paused = 1'b0;
    while (sb.n_items - start < n) begin
      r = $urandom_range(99);
      if (r < 40) send_frame(1);
      else if (r < 80) send_frame($urandom_range(2, 4));
      else send_frame($urandom_range(5, 12));
      if (pause_mid && !paused && sb.n_items - start >= n / 2) begin
        paused = 1'b1;
        drain();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: one-byte frames with both EOP polarities, all nibble codes.
    write_invert(1'b1);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    send_item(8'h01, 1'b1);
    send_item(8'h01, 1'b0);
    send_item(8'h23, 1'b0);
    send_item(8'h45, 1'b0);
    send_item(8'h67, 1'b0);
    send_item(8'h89, 1'b0);
    send_item(8'hAB, 1'b0);
    send_item(8'hCD, 1'b0);
    send_item(8'hEF, 1'b1);
    drain();
    write_invert(1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'h10, 1'b1);
    send_item(8'hFE, 1'b0);
    send_item(8'h5A, 1'b0);
    send_item(8'hA5, 1'b1);
    send_item(8'hFF, 1'b1);

    run_random(112, 7, 65, 1'b0, 1'b1);
    run_random(112, 65, 7, 1'b1, 1'b0);
    run_random(112, 0, 0, 1'($urandom_range(1)), 1'b0);

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d line bytes never came", sb.pending()));

    $display("Run covered %0d frame bytes in %0d frames, %0d line bytes checked,",
             sb.n_items, sb.n_frames, sb.n_bytes);
    $display("both line_invert settings, sender and receiver stalls; %0d mismatches.",
             sb.errors);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// File: sim.f
design/bmc_tx_pkg.sv
design/bmc_tx_front.sv
design/bmc_tx_queue.sv
design/bmc_tx_back.sv
design/bmc_frame_transmit_encoder.sv
test/testbench.sv
